### sv/hsrr_pkg.sv
// ============================================================================
// hsrr_pkg
// Shared types and constants of the humidity sensor read responder.
// ============================================================================
package hsrr_pkg;

  // Response layout: temperature high, low, CRC, humidity high, low, CRC.
  localparam int unsigned RespLen = 6;
  localparam int unsigned PosW    = 3;
  localparam logic [PosW-1:0] LastPos = PosW'(RespLen - 1);

  typedef enum logic {
    MODE_START = 1'b0,  // start read transfer, latch measurement
    MODE_READ  = 1'b1   // read one response byte
  } mode_e;

  typedef logic [7:0] resp_bytes_t [RespLen];

  typedef struct packed {
    logic load;  // write the six response bytes, clear the position
    logic read;  // return the byte at the position into the output register
  } store_ctrl_t;

endpackage

### sv/hsrr_conv.sv
// ============================================================================
// hsrr_conv
// Measurement to response bytes: raw counts plus CRC-8 per pair.
// ============================================================================
module hsrr_conv (
  input  logic signed [7:0]   temperature_i,
  input  logic        [6:0]   humidity_i,
  output hsrr_pkg::resp_bytes_t resp_o
);

  // x*65535/175 = 374*x + floor(17*x/35); 17*x/35 by reciprocal 7490/2^18.
  localparam logic [16:0] TempWhole = 17'd374;
  localparam logic [24:0] TempRecip = 25'd7490;
  // h*65535/100 = 655*h + floor(7*h/20); 7*h/20 by reciprocal 1639/2^15.
  localparam logic [16:0] HumWhole  = 17'd655;
  localparam logic [20:0] HumRecip  = 21'd1639;
  localparam logic [7:0]  CrcPoly   = 8'h31;
  localparam logic [7:0]  CrcInit   = 8'hFF;

  function automatic logic [7:0] crc8_byte(input logic [7:0] c_in, input logic [7:0] d);
    logic [7:0] c;
    c = c_in ^ d;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) c = {c[6:0], 1'b0} ^ CrcPoly;
      else      c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

  logic signed [8:0] t_shift;
  logic [7:0]  t_x;
  logic [11:0] t_n;
  logic [24:0] t_p;
  logic [16:0] t_sum;
  logic [15:0] raw_t;
  logic [9:0]  h_n;
  logic [20:0] h_p;
  logic [16:0] h_sum;
  logic [15:0] raw_h;

  assign t_shift = {temperature_i[7], temperature_i} + 9'sd45;
  // Cold clamp: below -45 degrees the count is zero.
  assign t_x     = t_shift[8] ? 8'd0 : t_shift[7:0];
  assign t_n     = 12'(t_x) * 12'd17;
  assign t_p     = 25'(t_n) * TempRecip;
  assign t_sum   = 17'(t_x) * TempWhole + 17'(t_p[24:18]);
  assign raw_t   = t_sum[16] ? 16'hFFFF : t_sum[15:0];

  assign h_n     = 10'(humidity_i) * 10'd7;
  assign h_p     = 21'(h_n) * HumRecip;
  assign h_sum   = 17'(humidity_i) * HumWhole + 17'(h_p[20:15]);
  assign raw_h   = h_sum[16] ? 16'hFFFF : h_sum[15:0];

  always_comb begin
    resp_o[0] = raw_t[15:8];
    resp_o[1] = raw_t[7:0];
    resp_o[2] = crc8_byte(crc8_byte(CrcInit, raw_t[15:8]), raw_t[7:0]);
    resp_o[3] = raw_h[15:8];
    resp_o[4] = raw_h[7:0];
    resp_o[5] = crc8_byte(crc8_byte(CrcInit, raw_h[15:8]), raw_h[7:0]);
  end

endmodule

### sv/hsrr_store.sv
// ============================================================================
// hsrr_store
// Response byte store, read position and output register.
// ============================================================================
module hsrr_store (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hsrr_pkg::store_ctrl_t ctrl_i,
  input  hsrr_pkg::resp_bytes_t resp_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [7:0]            out_data_o
);

  hsrr_pkg::resp_bytes_t             bytes_q;
  logic [hsrr_pkg::PosW-1:0]         pos_q, pos_d, pos_sel;
  logic                              out_valid_q;
  logic [7:0]                        out_data_q;

  assign pos_sel = (pos_q > hsrr_pkg::LastPos) ? hsrr_pkg::LastPos : pos_q;

  always_comb begin
    pos_d = pos_q;
    if (ctrl_i.load) begin
      pos_d = '0;
    end else if (ctrl_i.read && (pos_sel < hsrr_pkg::LastPos)) begin
      pos_d = pos_sel + 1'b1;
    end else if (ctrl_i.read) begin
      pos_d = pos_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hsrr_pkg::RespLen; i++) bytes_q[i] <= 8'd0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.load) bytes_q <= resp_i;
      pos_q <= pos_d;
      if (ctrl_i.read) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.read) out_data_q <= bytes_q[pos_sel];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= hsrr_pkg::LastPos)
    else $error("read position beyond last byte");

  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.load |=> pos_q == '0)
    else $error("position not cleared by start");

  a_read_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.read |=> out_valid_q)
    else $error("read byte not presented");

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.load && ctrl_i.read))
    else $error("start and read in the same cycle");

endmodule

### sv/humidity_sensor_read_responder_core.sv
// ============================================================================
// humidity_sensor_read_responder_core
// Read-side responder of a temperature/humidity sensor with CRC-8 bytes.
// ============================================================================
// A start transfer (tuser = 0) latches whole degrees C and whole percent RH,
// converts them to 16-bit raw counts, and stores six bytes: temperature
// high, low, CRC-8 (poly 0x31, init 0xFF), then the same for humidity; the
// read position goes back to zero and no result is produced. A read
// transfer (tuser = 1) returns the byte at the position and advances it,
// holding at the last byte on over-read. Each transfer passes the input
// register, then the store or output register. One transfer is accepted per
// cycle unless a read waits for output room: the input register holds the
// item and the conversion is a single pass of constant multiplies and CRC
// logic ahead of the store. The output register lets the next item in while
// a byte waits. Temperatures below -45 C clamp to a raw count of zero.
module humidity_sensor_read_responder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [7:0] temperature_c, [14:8] humidity_pct
  input  logic        s_axis_tuser_i,   // [0] mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o    // [7:0] read_data
);

  // Input register
  logic               in_valid_q;
  hsrr_pkg::mode_e    in_mode_q;
  logic signed [7:0]  in_temp_q;
  logic [6:0]         in_hum_q;

  hsrr_pkg::store_ctrl_t ctrl;
  hsrr_pkg::resp_bytes_t resp;
  logic                  out_valid;
  logic                  advance;

  // A start never waits; a read waits only for room in the output register.
  always_comb begin
    ctrl.load = in_valid_q && (in_mode_q == hsrr_pkg::MODE_START);
    ctrl.read = in_valid_q && (in_mode_q == hsrr_pkg::MODE_READ) &&
                (!out_valid || m_axis_tready_i);
  end

  assign advance         = ctrl.load || ctrl.read;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // Payload is captured on every accepted transfer; no reset needed.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_mode_q <= hsrr_pkg::mode_e'(s_axis_tuser_i);
      in_temp_q <= s_axis_tdata_i[7:0];
      in_hum_q  <= s_axis_tdata_i[14:8];
    end
  end

  hsrr_conv u_conv (
    .temperature_i (in_temp_q),
    .humidity_i    (in_hum_q),
    .resp_o        (resp)
  );

  hsrr_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .resp_i      (resp),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (out_valid),
    .out_data_o  (m_axis_tdata_o)
  );

  assign m_axis_tvalid_o = out_valid;

endmodule
